[hdl/dppa_pkg.sv]
// dppa_pkg: shared codes, masks and structs for the dual parallel port adapter
// used by dppa_port and dual_parallel_port_adapter; no dependencies
`default_nettype none

package dppa_pkg;

  // item modes
  localparam logic [1:0] MODE_READ  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;

  // register addresses
  localparam logic [1:0] REG_DATA_A = 2'd0;
  localparam logic [1:0] REG_CTRL_A = 2'd1;
  localparam logic [1:0] REG_DATA_B = 2'd2;
  localparam logic [1:0] REG_CTRL_B = 2'd3;

  // control register fields
  localparam logic [7:0] KEEP_LOW_MASK = 8'h3f;
  localparam logic [7:0] FLAG_MASK     = 8'hc0;
  localparam logic [7:0] IRQ1_BIT      = 8'h80;
  localparam int unsigned CTRL_EN_IDX      = 0;
  localparam int unsigned CTRL_RISE_IDX    = 1;
  localparam int unsigned CTRL_SEL_OUT_IDX = 2;
  localparam int unsigned CTRL_IRQ1_IDX    = 7;

  // operation on one port, decoded from an item
  typedef struct packed {
    logic rd_data;
    logic wr_data;
    logic wr_ctrl;
    logic tick;
  } port_op_t;

  // register view of one port
  typedef struct packed {
    logic [7:0] ctrl;
    logic [7:0] dir;
    logic [7:0] outr;
    logic       flag_next;
  } port_view_t;

endpackage

`default_nettype wire

[hdl/dual_parallel_port_adapter.sv]
// dual_parallel_port_adapter: top level with input stage, register decode
// and result register; depends on dppa_pkg and dppa_port
//
// usage:
//   input channel in_valid/in_ready carries one item: a register read, a
//   register write or a tick that samples the CA1/CB1 lines
//   output channel out_valid/out_ready carries one result per item:
//   read_data (zero for writes and ticks) and the two interrupt flags
//   as they stand after the item
// timing:
//   an accepted item lands in the input stage register; once the result
//   slot is free it is decoded, applied to the port registers and its result
//   is loaded into the result register; one item per cycle sustained while
//   out_ready is held high
// stall:
//   while the result waits, one more item is held in the input stage;
//   in_ready drops only when both are full
// reset:
//   rst clears all port registers, the edge history and both valid flags
`default_nettype none

module dual_parallel_port_adapter (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] mode,
  input  wire logic [1:0] reg_sel,
  input  wire logic [7:0] write_data,
  input  wire logic [7:0] pins_a,
  input  wire logic [7:0] pins_b,
  input  wire logic       ca1_level,
  input  wire logic       cb1_level,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      read_data,
  output logic            flag_a,
  output logic            flag_b
);

  import dppa_pkg::*;

  logic       s_valid;
  logic [1:0] s_mode;
  logic [1:0] s_sel;
  logic [7:0] s_wdata;
  logic [7:0] s_pins_a;
  logic [7:0] s_pins_b;
  logic       s_ca1;
  logic       s_cb1;
  logic       fire;
  port_op_t   op_a;
  port_op_t   op_b;
  port_view_t view_a;
  port_view_t view_b;
  logic [7:0] rd_value;

  // item moves from stage to result register when the result slot is free
  assign fire     = s_valid && (!out_valid || out_ready);
  assign in_ready = !s_valid || fire;

  // input stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_ready) begin
      s_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_mode   <= mode;
      s_sel    <= reg_sel;
      s_wdata  <= write_data;
      s_pins_a <= pins_a;
      s_pins_b <= pins_b;
      s_ca1    <= ca1_level;
      s_cb1    <= cb1_level;
    end
  end

  // decode per port
  always_comb begin
    op_a.rd_data = (s_mode == MODE_READ)  && (s_sel == REG_DATA_A);
    op_a.wr_data = (s_mode == MODE_WRITE) && (s_sel == REG_DATA_A);
    op_a.wr_ctrl = (s_mode == MODE_WRITE) && (s_sel == REG_CTRL_A);
    op_a.tick    = (s_mode == MODE_TICK);
    op_b.rd_data = (s_mode == MODE_READ)  && (s_sel == REG_DATA_B);
    op_b.wr_data = (s_mode == MODE_WRITE) && (s_sel == REG_DATA_B);
    op_b.wr_ctrl = (s_mode == MODE_WRITE) && (s_sel == REG_CTRL_B);
    op_b.tick    = (s_mode == MODE_TICK);
  end

  dppa_port u_port_a (
    .clk        (clk),
    .rst        (rst),
    .en         (fire),
    .op         (op_a),
    .write_data (s_wdata),
    .level      (s_ca1),
    .view       (view_a)
  );

  dppa_port u_port_b (
    .clk        (clk),
    .rst        (rst),
    .en         (fire),
    .op         (op_b),
    .write_data (s_wdata),
    .level      (s_cb1),
    .view       (view_b)
  );

  // read data mux
  always_comb begin
    rd_value = '0;
    if (s_mode == MODE_READ) begin
      case (s_sel)
        REG_DATA_A: begin
          if (view_a.ctrl[CTRL_SEL_OUT_IDX]) begin
            rd_value = (~view_a.dir & s_pins_a) | (view_a.dir & view_a.outr & s_pins_a);
          end else begin
            rd_value = view_a.dir;
          end
        end
        REG_CTRL_A: rd_value = view_a.ctrl;
        REG_DATA_B: begin
          if (view_b.ctrl[CTRL_SEL_OUT_IDX]) begin
            rd_value = (~view_b.dir & s_pins_b) | (view_b.dir & view_b.outr);
          end else begin
            rd_value = view_b.dir;
          end
        end
        REG_CTRL_B: rd_value = view_b.ctrl;
        default:    rd_value = '0;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      read_data <= rd_value;
      flag_a    <= view_a.flag_next;
      flag_b    <= view_b.flag_next;
    end
  end

`ifndef SYNTHESIS
  // input backpressure only when stage and result are both full
  a_ready_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (s_valid && out_valid && !out_ready))
    else $error("in_ready low while a slot is free");

  // writes and ticks return zero
  a_zero_on_non_read: assert property (@(posedge clk) disable iff (rst)
    (fire && (s_mode != MODE_READ)) |=> (read_data == 8'd0))
    else $error("non-zero read_data for a write or tick item");

  // reported flag matches the stored control bit
  a_flag_a_tracks_ctrl: assert property (@(posedge clk) disable iff (rst)
    fire |=> (flag_a == view_a.ctrl[CTRL_IRQ1_IDX]))
    else $error("flag_a differs from control A bit 7");

  // output register read of port B clears its flag
  a_flag_b_clear_on_read: assert property (@(posedge clk) disable iff (rst)
    (fire && op_b.rd_data && view_b.ctrl[CTRL_SEL_OUT_IDX]) |=> !flag_b)
    else $error("flag_b not cleared by output register read");
`endif

endmodule

`default_nettype wire

[hdl/dppa_port.sv]
// dppa_port: direction, output and control registers of one port plus
// the control line edge detector; depends on dppa_pkg
`default_nettype none

module dppa_port (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire dppa_pkg::port_op_t op,
  input  wire logic [7:0]         write_data,
  input  wire logic               level,
  output dppa_pkg::port_view_t    view
);

  import dppa_pkg::*;

  logic [7:0] ctrl;
  logic [7:0] ctrl_next;
  logic [7:0] dir;
  logic [7:0] outr;
  logic       last_level;
  logic       edge_hit;

  // edge of the selected polarity against the last sampled level
  assign edge_hit = ctrl[CTRL_EN_IDX] &&
                    ((ctrl[CTRL_RISE_IDX] && !last_level && level) ||
                     (!ctrl[CTRL_RISE_IDX] && last_level && !level));

  // control register next value
  always_comb begin
    ctrl_next = ctrl;
    if (en) begin
      if (op.rd_data && ctrl[CTRL_SEL_OUT_IDX]) begin
        ctrl_next = ctrl & KEEP_LOW_MASK;
      end else if (op.wr_ctrl) begin
        ctrl_next = (write_data & KEEP_LOW_MASK) | (ctrl & FLAG_MASK);
      end else if (op.tick && edge_hit) begin
        ctrl_next = ctrl | IRQ1_BIT;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl       <= '0;
      dir        <= '0;
      outr       <= '0;
      last_level <= 1'b0;
    end else begin
      ctrl <= ctrl_next;
      if (en && op.wr_data) begin
        if (ctrl[CTRL_SEL_OUT_IDX]) begin
          outr <= write_data;
        end else begin
          dir <= write_data;
        end
      end
      if (en && op.tick) begin
        last_level <= level;
      end
    end
  end

  assign view.ctrl      = ctrl;
  assign view.dir       = dir;
  assign view.outr      = outr;
  assign view.flag_next = ctrl_next[CTRL_IRQ1_IDX];

endmodule

`default_nettype wire
